### hw/rtl/time_decayed_density_counter_macros.svh
// ----------------------------------------------------------------------------
// time_decayed_density_counter_macros
// assertion macros used by the density counter core (tdd_core)
// ----------------------------------------------------------------------------
`ifndef TIME_DECAYED_DENSITY_COUNTER_MACROS_SVH
`define TIME_DECAYED_DENSITY_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdd assertion failed");

// next-cycle implication
`define TDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdd assertion failed");

`else

`define TDD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/tdd_pkg.sv
// ----------------------------------------------------------------------------
// tdd_pkg
// shared constants and types of the time-decayed density counter
// ----------------------------------------------------------------------------
package tdd_pkg;

  // default parameter values
  localparam int unsigned TIME_BITS_DEF        = 32;
  localparam int unsigned FACTOR_FRAC_BITS_DEF = 16;

  // fixed record increment position, Q16.16 density
  localparam int unsigned DENSITY_FRAC_BITS = 16;

  // field widths
  localparam int unsigned TIME_NOW_W   = 32;
  localparam int unsigned DENSITY_W    = 32;
  localparam int unsigned FACTOR_REG_W = 16;

  // register file
  localparam logic [FACTOR_REG_W-1:0] FACTOR_RST = 16'd65405;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_LSB = 2;
  localparam logic        REG_FACTOR  = 1'b0;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POW,
    S_SCALE,
    S_DONE
  } tdd_state_e;

endpackage

### hw/rtl/tdd_in_if.sv
// ----------------------------------------------------------------------------
// tdd_in_if
// input item channel: command and timestamp
// ----------------------------------------------------------------------------
interface tdd_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [tdd_pkg::TIME_NOW_W-1:0]  tstamp;

  modport source (output valid, output cmd, output tstamp, input ready);
  modport sink   (input valid, input cmd, input tstamp, output ready);
endinterface

### hw/rtl/tdd_out_if.sv
// ----------------------------------------------------------------------------
// tdd_out_if
// result channel: density and saturation flag
// ----------------------------------------------------------------------------
interface tdd_out_if;
  logic                           valid;
  logic                           ready;
  logic [tdd_pkg::DENSITY_W-1:0]  density_out;
  logic                           saturated;

  modport source (output valid, output density_out, output saturated, input ready);
  modport sink   (input valid, input density_out, input saturated, output ready);
endinterface

### hw/rtl/time_decayed_density_counter.sv
// ----------------------------------------------------------------------------
// time_decayed_density_counter
// exponentially decayed event density with apb-programmable decay factor
// ----------------------------------------------------------------------------
// Each input beat carries a timestamp and a command (decay only, or decay and
// add one record). The block raises the Q0.16 decay factor to the elapsed
// time (timestamp minus last timestamp, modulo 2^TIME_BITS) by square-and-
// multiply with truncation, scales the stored Q16.16 density by it, adds 1.0
// on a record, clamps at all ones and returns one result beat. All products
// go through a single multiplier, one per cycle, so the input is not ready
// again until an item has passed through the power, scale and result
// steps. A finished result waits in an output register while the next item
// is accepted. The user must write the decay factor only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module time_decayed_density_counter #(
  parameter int unsigned TIME_BITS        = tdd_pkg::TIME_BITS_DEF,
  parameter int unsigned FACTOR_FRAC_BITS = tdd_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tdd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tdd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  tdd_in_if.sink                          item_i,
  tdd_out_if.source                       result_o
);

  logic [tdd_pkg::FACTOR_REG_W-1:0] factor_val;

  // configuration registers
  tdd_apb u_apb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .factor_o (factor_val)
  );

  // decay sequencer and shared multiplier
  tdd_core #(
    .TIME_BITS        (TIME_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .factor_i (factor_val),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule

### hw/rtl/tdd_apb.sv
// ----------------------------------------------------------------------------
// tdd_apb
// apb register slice holding the decay factor
// ----------------------------------------------------------------------------
module tdd_apb (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tdd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tdd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tdd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [tdd_pkg::FACTOR_REG_W-1:0]  factor_o
);

  logic [tdd_pkg::FACTOR_REG_W-1:0] decay_q, decay_d;
  logic                             hit;

  // address decode
  assign hit = (paddr[tdd_pkg::REG_IDX_LSB] == tdd_pkg::REG_FACTOR);

  // write on the access phase
  always_comb begin
    decay_d = decay_q;
    if (psel && penable && pwrite && hit) begin
      decay_d = pwdata[tdd_pkg::FACTOR_REG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= tdd_pkg::FACTOR_RST;
    end else begin
      decay_q <= decay_d;
    end
  end

  // read back
  assign prdata = hit ? tdd_pkg::APB_DATA_W'(decay_q) : '0;
  assign pready = 1'b1;

  assign factor_o = decay_q;

endmodule

### hw/rtl/tdd_mul.sv
// ----------------------------------------------------------------------------
// tdd_mul
// shared multiplier with truncating fixed-point rescale
// ----------------------------------------------------------------------------
module tdd_mul #(
  parameter int unsigned FACTOR_FRAC_BITS = tdd_pkg::FACTOR_FRAC_BITS_DEF,
  parameter int unsigned A_W              = tdd_pkg::DENSITY_W
) (
  input  logic [A_W-1:0]              a_i,
  input  logic [FACTOR_FRAC_BITS:0]   b_i,
  output logic [A_W-1:0]              p_o
);

  localparam int unsigned B_W    = FACTOR_FRAC_BITS + 1;
  localparam int unsigned PROD_W = A_W + B_W;

  logic [PROD_W-1:0] prod;

  // full product, then drop the fraction bits of the factor
  assign prod = PROD_W'(a_i) * PROD_W'(b_i);
  assign p_o  = prod[FACTOR_FRAC_BITS +: A_W];

endmodule

### hw/rtl/tdd_core.sv
// ----------------------------------------------------------------------------
// tdd_core
// sequencer: square-and-multiply power, density scale, record and saturate
// ----------------------------------------------------------------------------
`include "time_decayed_density_counter_macros.svh"

module tdd_core #(
  parameter int unsigned TIME_BITS        = tdd_pkg::TIME_BITS_DEF,
  parameter int unsigned FACTOR_FRAC_BITS = tdd_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [tdd_pkg::FACTOR_REG_W-1:0] factor_i,
  tdd_in_if.sink                           item_i,
  tdd_out_if.source                        result_o
);

  localparam int unsigned F       = FACTOR_FRAC_BITS;
  localparam int unsigned DW      = tdd_pkg::DENSITY_W;
  localparam int unsigned STORE_W = (TIME_BITS < tdd_pkg::TIME_NOW_W) ?
                                    TIME_BITS : tdd_pkg::TIME_NOW_W;
  localparam int unsigned A_W     = (F + 1 > DW) ? F + 1 : DW;
  localparam int unsigned SUM_W   = DW + 2;

  tdd_pkg::tdd_state_e state_q, state_d;

  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic [STORE_W-1:0]   last_q, last_d;
  logic [F-1:0]         base_q, base_d;
  logic [F:0]           pow_q, pow_d;
  logic                 cmd_q, cmd_d;
  logic [DW-1:0]        dens_q, dens_d;
  logic [DW-1:0]        scaled_q, scaled_d;
  logic                 out_valid_q, out_valid_d;
  logic [DW-1:0]        out_dens_q, out_dens_d;
  logic                 out_sat_q, out_sat_d;

  logic [STORE_W-1:0]   now_t;
  logic [F-1:0]         base_init;
  logic [F:0]           pow_one;
  logic [A_W-1:0]       mul_a;
  logic [F:0]           mul_b;
  logic [A_W-1:0]       mul_p;
  logic [SUM_W-1:0]     rec_inc;
  logic [SUM_W-1:0]     sum;
  logic                 sat;

  assign now_t   = item_i.tstamp[STORE_W-1:0];
  assign pow_one = {1'b1, {F{1'b0}}};

  // factor register bits that fall inside the fraction
  if (F >= tdd_pkg::FACTOR_REG_W) begin : g_base_wide
    assign base_init = F'(factor_i);
  end else begin : g_base_narrow
    assign base_init = factor_i[F-1:0];
  end

  // shared multiply unit
  tdd_mul #(
    .FACTOR_FRAC_BITS (F),
    .A_W              (A_W)
  ) u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // record increment and clamp
  assign rec_inc = cmd_q ? (SUM_W'(1) << tdd_pkg::DENSITY_FRAC_BITS) : '0;
  assign sum     = SUM_W'(scaled_q) + rec_inc;
  assign sat     = (sum >= SUM_W'({DW{1'b1}}));

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    last_d      = last_q;
    base_d      = base_q;
    pow_d       = pow_q;
    cmd_d       = cmd_q;
    dens_d      = dens_q;
    scaled_d    = scaled_q;
    out_valid_d = out_valid_q;
    out_dens_d  = out_dens_q;
    out_sat_d   = out_sat_q;
    mul_a       = '0;
    mul_b       = '0;

    // result beat taken
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tdd_pkg::S_IDLE: begin
        if (item_i.valid) begin
          elapsed_d = TIME_BITS'(now_t) - TIME_BITS'(last_q);
          last_d    = now_t;
          base_d    = base_init;
          pow_d     = pow_one;
          cmd_d     = item_i.cmd;
          state_d   = tdd_pkg::S_POW;
        end
      end
      tdd_pkg::S_POW: begin
        if (elapsed_q == '0) begin
          state_d = tdd_pkg::S_SCALE;
        end else if (elapsed_q[0]) begin
          // fold the current base into the power
          mul_a        = A_W'(pow_q);
          mul_b        = (F + 1)'(base_q);
          pow_d        = mul_p[F:0];
          elapsed_d[0] = 1'b0;
        end else begin
          // square the base, move to the next exponent bit
          mul_a     = A_W'(base_q);
          mul_b     = (F + 1)'(base_q);
          base_d    = mul_p[F-1:0];
          elapsed_d = elapsed_q >> 1;
        end
      end
      tdd_pkg::S_SCALE: begin
        mul_a    = A_W'(dens_q);
        mul_b    = pow_q;
        scaled_d = mul_p[DW-1:0];
        state_d  = tdd_pkg::S_DONE;
      end
      tdd_pkg::S_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          dens_d      = sat ? {DW{1'b1}} : sum[DW-1:0];
          out_dens_d  = sat ? {DW{1'b1}} : sum[DW-1:0];
          out_sat_d   = sat;
          out_valid_d = 1'b1;
          state_d     = tdd_pkg::S_IDLE;
        end
      end
    endcase
  end

  // control state and stored density
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      dens_q      <= '0;
      last_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dens_q      <= dens_d;
      last_q      <= last_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    elapsed_q  <= elapsed_d;
    base_q     <= base_d;
    pow_q      <= pow_d;
    cmd_q      <= cmd_d;
    scaled_q   <= scaled_d;
    out_dens_q <= out_dens_d;
    out_sat_q  <= out_sat_d;
  end

  // channel outputs
  assign item_i.ready         = (state_q == tdd_pkg::S_IDLE);
  assign result_o.valid       = out_valid_q;
  assign result_o.density_out = out_dens_q;
  assign result_o.saturated   = out_sat_q;

  // checks
  `TDD_ASSERT_NEXT(a_accept_starts_pow, clk_i, rst_ni, item_i.valid && item_i.ready, state_q == tdd_pkg::S_POW)
  `TDD_ASSERT_IMPL(a_scale_after_pow, clk_i, rst_ni, state_q == tdd_pkg::S_SCALE, elapsed_q == '0)
  `TDD_ASSERT_IMPL(a_pow_at_most_one, clk_i, rst_ni, state_q == tdd_pkg::S_POW, pow_q <= pow_one)
  `TDD_ASSERT_IMPL(a_sat_means_max, clk_i, rst_ni, out_valid_q && out_sat_q, out_dens_q == {DW{1'b1}})

endmodule
